FILE: design/scsa_pkg.sv
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types and constants of the size class slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

  localparam int unsigned ClassNum       = 6;
  localparam int unsigned ChunksPerClass = 16;
  localparam int unsigned MaxSlots       = 64;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_CLASS  = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  function automatic logic [31:0] slot_size(input logic [2:0] c);
    logic [31:0] r;
    case (c)
      3'd0:    r = 32'd256;
      3'd1:    r = 32'd4096;
      3'd2:    r = 32'd131072;
      3'd3:    r = 32'd1048576;
      3'd4:    r = 32'd10485760;
      default: r = 32'd83886080;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] slots_raw(input logic [2:0] c);
    logic [7:0] r;
    case (c)
      3'd0, 3'd1, 3'd2: r = 8'd64;
      3'd3:             r = 8'd32;
      3'd4:             r = 8'd8;
      default:          r = 8'd2;
    endcase
    return r;
  endfunction

endpackage

FILE: design/size_class_slab_allocator_core.sv
// ----------------------------------------------------------------------------
// size_class_slab_allocator_core
// Slab allocator over six size classes; per chunk slot maps, counts and stamps live in one RAM.
// Sequence: an allocate walks the chunks of its class through the single RAM
// read port (S_WALK, S_WALK2), then scans the slots of the picked chunk one slot
// per cycle; a free reads, checks and writes back one chunk.
// Throughput: one request at a time; busy drops in the cycle of the result strobe.
// Reset: rst_ni clears control state and all valid bits, so every chunk
// reads as unused at once. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module size_class_slab_allocator_core #(
  parameter int unsigned CHUNKS_PER_CLASS = scsa_pkg::ChunksPerClass,
  parameter int unsigned MAX_SLOTS        = scsa_pkg::MaxSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [31:0] req_size_i,
  input  logic [31:0] req_align_i,
  input  logic        want_linear_i,
  input  logic [2:0]  free_class_i,
  input  logic [3:0]  free_chunk_i,
  input  logic [26:0] free_offset_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [2:0]  class_out_o,
  output logic [3:0]  chunk_out_o,
  output logic [26:0] offset_out_o,
  output logic        chunk_fresh_o,
  output logic        chunk_released_o
);
  import scsa_pkg::*;

  localparam int unsigned NChunk = ClassNum * CHUNKS_PER_CLASS;
  localparam int unsigned AW     = $clog2(NChunk);
  localparam int unsigned KW     = (CHUNKS_PER_CLASS > 1) ? $clog2(CHUNKS_PER_CLASS) : 1;
  localparam int unsigned SW     = $clog2(MAX_SLOTS);
  localparam int unsigned UW     = SW + 1;
  localparam int unsigned EW     = MAX_SLOTS + UW + 1 + 32;

  typedef struct packed {
    logic [MAX_SLOTS-1:0] smap;
    logic [UW-1:0]        used;
    logic                 lin;
    logic [31:0]          stamp;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLS, S_FREE_RD, S_FREE_CHK, S_WALK, S_WALK2, S_PICK, S_PICK_RD,
    S_SCAN, S_WR, S_DONE
  } state_e;

  state_e state_q;
  logic [NChunk-1:0] act_q, ever_q;
  logic [31:0] ctr_q [ClassNum];
  logic        lin_q;
  logic [31:0] size_q, align_q;
  logic [2:0]  cls_q;
  logic [KW:0] k_q;
  logic [26:0] off_q;
  logic        found_q, idle_q, never_q, fresh_q, rel_q;
  logic [KW-1:0] pick_q, idle_i_q, never_i_q;
  logic [31:0] best_q, ibest_q;
  logic [SW:0] slot_q;
  logic [3:0]  sgrp_q;
  logic [MAX_SLOTS-1:0] map_q;
  logic [UW-1:0] used_q;
  logic [1:0] st_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic          csel_vld;
  logic [2:0]    csel_cls;

  scsa_ram #(.Width(EW), .Depth(NChunk)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  scsa_class_sel u_csel (
    .clk_i, .size_i(size_q), .align_i(align_q), .valid_o(csel_vld), .class_o(csel_cls)
  );

  function automatic logic [AW-1:0] idx(input logic [2:0] c, input logic [KW-1:0] k);
    return AW'(32'(c) * CHUNKS_PER_CLASS + 32'(k));
  endfunction

  function automatic logic [31:0] slot_index(input logic [2:0] c, input logic [26:0] off);
    logic [31:0] r;
    case (c)
      3'd0: r = 32'(off >> 8);
      3'd1: r = 32'(off >> 12);
      3'd2: r = 32'(off >> 17);
      3'd3: r = 32'(off >> 20);
      3'd4: begin
        r = '0;
        for (int j = 1; j <= 12; j++) begin
          if (32'(off) >= 32'(j) * 32'd10485760) r = 32'(j);
        end
      end
      default: r = (32'(off) >= 32'd83886080) ? 32'd1 : 32'd0;
    endcase
    return r;
  endfunction

  logic [31:0] age;
  logic [KW-1:0] kk;
  logic [AW-1:0] xcur;
  logic [UW-1:0] nsl;
  logic [31:0] fslot;
  always_comb begin
    kk   = k_q[KW-1:0] - KW'(1);
    xcur = idx(cls_q, kk);
    age  = ctr_q[cls_q] - rdata.stamp;
    nsl  = (32'(slots_raw(cls_q)) > MAX_SLOTS) ? UW'(MAX_SLOTS) : UW'(slots_raw(cls_q));
    fslot = slot_index(cls_q, off_q);
  end

  always_comb begin
    raddr = (state_q == S_WALK) ? idx(cls_q, k_q[KW-1:0]) : idx(cls_q, pick_q);
    if (state_q == S_FREE_RD) raddr = idx(cls_q, k_q[KW-1:0]);
    we    = 1'b0;
    waddr = idx(cls_q, pick_q);
    wdata = '{smap: map_q, used: used_q, lin: lin_q, stamp: rdata.stamp};
    if (state_q == S_WR) begin
      we = 1'b1;
      if (rel_q || (fresh_q || !found_q)) wdata.stamp = best_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= '0;
      ever_q  <= '0;
      for (int c = 0; c < ClassNum; c++) ctr_q[c] <= '0;
      done_o  <= 1'b0;
      status_o <= ST_OK;
      class_out_o <= '0; chunk_out_o <= '0; offset_out_o <= '0;
      chunk_fresh_o <= 1'b0; chunk_released_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start) begin
          size_q <= req_size_i; align_q <= req_align_i;
          lin_q <= want_linear_i; off_q <= free_offset_i;
          cls_q <= free_class_i; k_q <= (KW+1)'(free_chunk_i);
          found_q <= 1'b0; idle_q <= 1'b0; never_q <= 1'b0;
          fresh_q <= 1'b0; rel_q <= 1'b0; st_q <= ST_OK;
          if (cmd_i == CMD_FREE) begin
            if (free_class_i >= 3'(ClassNum) || 32'(free_chunk_i) >= CHUNKS_PER_CLASS) begin
              st_q <= ST_BAD_FREE; state_q <= S_DONE;
            end else state_q <= S_FREE_RD;
          end else state_q <= S_CLS;
        end
        S_CLS: state_q <= S_PICK;
        S_PICK: begin
          if (!csel_vld) begin st_q <= ST_NO_CLASS; state_q <= S_DONE; end
          else begin cls_q <= csel_cls; k_q <= '0; state_q <= S_WALK; end
        end
        S_WALK: begin
          k_q <= k_q + (KW+1)'(1); state_q <= S_WALK2;
        end
        S_WALK2: begin
          if (act_q[xcur]) begin
            if (rdata.used < nsl && rdata.lin == lin_q && (!found_q || age > best_q)) begin
              found_q <= 1'b1; pick_q <= kk; best_q <= age;
            end
          end else if (ever_q[xcur]) begin
            if (!idle_q || age > ibest_q) begin idle_q <= 1'b1; idle_i_q <= kk; ibest_q <= age; end
          end else if (!never_q) begin never_q <= 1'b1; never_i_q <= kk; end
          if (32'(k_q) == CHUNKS_PER_CLASS) state_q <= S_PICK_RD;
          else state_q <= S_WALK;
        end
        S_PICK_RD: begin
          if (found_q) begin
            state_q <= S_SCAN; slot_q <= '0; sgrp_q <= '0;
          end else if (idle_q || never_q) begin
            pick_q  <= idle_q ? idle_i_q : never_i_q;
            fresh_q <= !idle_q;
            act_q[idx(cls_q, idle_q ? idle_i_q : never_i_q)]  <= 1'b1;
            ever_q[idx(cls_q, idle_q ? idle_i_q : never_i_q)] <= 1'b1;
            best_q <= ctr_q[cls_q];
            ctr_q[cls_q] <= ctr_q[cls_q] + 32'd1;
            map_q <= '0; used_q <= '0;
            slot_q <= '0; sgrp_q <= '1;
            state_q <= S_SCAN;
          end else begin st_q <= ST_EXHAUSTED; state_q <= S_DONE; end
        end
        S_SCAN: begin
          if (sgrp_q == 4'd0) begin
            map_q <= rdata.smap; used_q <= rdata.used; sgrp_q <= 4'd1;
          end else begin
            if (32'(slot_q) >= 32'(nsl)) begin st_q <= ST_EXHAUSTED; state_q <= S_DONE; end
            else if (!map_q[slot_q[SW-1:0]]) begin
              map_q[slot_q[SW-1:0]] <= 1'b1; used_q <= used_q + UW'(1); state_q <= S_WR;
            end else slot_q <= slot_q + (SW+1)'(1);
          end
        end
        S_FREE_RD: begin
          pick_q <= k_q[KW-1:0]; state_q <= S_FREE_CHK;
        end
        S_FREE_CHK: begin
          slot_q <= fslot[SW:0];
          if (fslot >= 32'(nsl) || !act_q[idx(cls_q, pick_q)] ||
              !rdata.smap[fslot[SW-1:0]] || rdata.used == '0) begin
            st_q <= ST_BAD_FREE; state_q <= S_DONE;
          end else begin
            map_q <= rdata.smap & ~(MAX_SLOTS'(1) << fslot[SW-1:0]);
            lin_q <= rdata.lin;
            used_q <= rdata.used - UW'(1); found_q <= 1'b1;
            if (rdata.used == UW'(1)) begin
              rel_q <= 1'b1; act_q[idx(cls_q, pick_q)] <= 1'b0;
              best_q <= ctr_q[cls_q]; ctr_q[cls_q] <= ctr_q[cls_q] + 32'd1;
            end
            state_q <= S_WR;
          end
        end
        S_WR: state_q <= S_DONE;
        S_DONE: begin
          done_o <= 1'b1; status_o <= st_q;
          if (st_q == ST_OK) begin
            class_out_o <= cls_q; chunk_out_o <= 4'(pick_q);
            offset_out_o <= 27'(32'(slot_q) * slot_size(cls_q));
            chunk_fresh_o <= fresh_q; chunk_released_o <= rel_q;
          end else begin
            class_out_o <= '0; chunk_out_o <= '0; offset_out_o <= '0;
            chunk_fresh_o <= 1'b0; chunk_released_o <= 1'b0;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);
endmodule

FILE: design/scsa_ram.sv
// ----------------------------------------------------------------------------
// scsa_ram
// Generic simple dual port synchronous RAM (one write port, one read port) with a registered read.
// ----------------------------------------------------------------------------
module scsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: design/scsa_class_sel.sv
// ----------------------------------------------------------------------------
// scsa_class_sel
// Registered size class selection from request size and alignment.
// ----------------------------------------------------------------------------
module scsa_class_sel (
  input  logic        clk_i,
  input  logic [31:0] size_i,
  input  logic [31:0] align_i,
  output logic        valid_o,
  output logic [2:0]  class_o
);
  import scsa_pkg::*;

  logic       vld_d;
  logic [2:0] cls_d;
  logic [2:0] base;
  logic       hit;

  always_comb begin
    base = 3'd0;
    hit  = 1'b0;
    for (int c = 5; c >= 0; c--) begin
      if (size_i <= slot_size(3'(c))) begin
        base = 3'(c);
        hit  = 1'b1;
      end
    end
    vld_d = 1'b0;
    cls_d = 3'd0;
    if (size_i != 32'd0 && align_i != 32'd0 && hit) begin
      for (int k = 5; k >= 0; k--) begin
        if (3'(k) >= base && align_i <= slot_size(3'(k))) begin
          vld_d = 1'b1;
          cls_d = 3'(k);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    valid_o <= vld_d;
    class_o <= cls_d;
  end
endmodule

FILE: design/scsa_checker.sv
// ----------------------------------------------------------------------------
// scsa_checker
// Port level checks of the slab allocator core.
// ----------------------------------------------------------------------------
module scsa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [1:0] status_o,
  input logic       chunk_fresh_o,
  input logic       chunk_released_o,
  input logic [26:0] offset_out_o
);
  import scsa_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accept did not raise busy");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (!chunk_fresh_o && !chunk_released_o &&
    offset_out_o == '0)) else $error("error result carries payload");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(chunk_fresh_o && chunk_released_o)) else $error("both flags set");
endmodule

bind size_class_slab_allocator_core scsa_checker u_scsa_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .status_o,
  .chunk_fresh_o, .chunk_released_o, .offset_out_o
);

FILE: verif/tb_size_class_slab_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_size_class_slab_allocator_core
// Drives allocate and free requests into the slab allocator, predicts every
// response with a cycle-free model of the class pools, and compares each
// strobed response field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_size_class_slab_allocator_core;
  import scsa_pkg::*;

  localparam int unsigned NumChunks = ClassNum * ChunksPerClass;
  localparam int unsigned WatchLimit = 5000;

  typedef struct packed {
    status_e     st;
    logic [2:0]  cls;
    logic [3:0]  chunk;
    logic [26:0] off;
    logic        fresh;
    logic        rel;
  } slab_result_t;

  typedef struct packed {
    logic [2:0]  cls;
    logic [3:0]  chunk;
    logic [26:0] off;
  } live_slot_t;

  class alloc_scoreboard;
    logic [63:0] slot_map [NumChunks];
    int unsigned used_cnt [NumChunks];
    bit          active [NumChunks];
    bit          ever_used [NumChunks];
    bit          linear_kind [NumChunks];
    logic [31:0] stamp_of [NumChunks];
    logic [31:0] class_clock [ClassNum];
    slab_result_t pending[$];
    int unsigned errors;
    int unsigned n_checked;
    int unsigned status_seen [4];

    function new();
      for (int i = 0; i < NumChunks; i++) begin
        slot_map[i] = '0;
        used_cnt[i] = 0;
        active[i] = 0;
        ever_used[i] = 0;
        linear_kind[i] = 0;
        stamp_of[i] = '0;
      end
      for (int c = 0; c < ClassNum; c++) class_clock[c] = '0;
      errors = 0;
      n_checked = 0;
      for (int s = 0; s < 4; s++) status_seen[s] = 0;
    endfunction

    function logic [31:0] bytes_per_slot(int unsigned c);
      case (c)
        0: return 32'd256;
        1: return 32'd4096;
        2: return 32'd131072;
        3: return 32'd1048576;
        4: return 32'd10485760;
        default: return 32'd83886080;
      endcase
    endfunction

    function int unsigned slot_count(int unsigned c);
      case (c)
        0, 1, 2: return 64;
        3: return 32;
        4: return 8;
        default: return 2;
      endcase
    endfunction

    function int pick_class(logic [31:0] size, logic [31:0] align);
      logic [31:0] lo;
      lo = '0;
      if (size == 0 || align == 0) return -1;
      for (int c = 0; c < ClassNum; c++) begin
        if (size > lo && size <= bytes_per_slot(c)) begin
          for (int k = c; k < ClassNum; k++)
            if (align <= bytes_per_slot(k)) return k;
          return -1;
        end
        lo = bytes_per_slot(c);
      end
      return -1;
    endfunction

    function void restamp(int unsigned c, int unsigned x);
      stamp_of[x] = class_clock[c];
      class_clock[c] = class_clock[c] + 32'd1;
    endfunction

    function slab_result_t log_request(cmd_e cmd, logic [31:0] size, logic [31:0] align,
                                       logic lin, logic [2:0] fcls, logic [3:0] fchunk,
                                       logic [26:0] foff);
      slab_result_t r;
      int cls, pick, idle, never;
      int unsigned base, x, s, n;
      logic [31:0] age, best;
      r = '{st: ST_OK, default: '0};
      if (cmd == CMD_ALLOC) begin
        cls = pick_class(size, align);
        if (cls < 0) begin
          r.st = ST_NO_CLASS;
        end else begin
          base = cls * ChunksPerClass;
          n = slot_count(cls);
          pick = -1;
          best = '0;
          for (int i = 0; i < ChunksPerClass; i++) begin
            age = class_clock[cls] - stamp_of[base + i];
            if (active[base + i] && used_cnt[base + i] < n &&
                linear_kind[base + i] == lin && (pick < 0 || age > best)) begin
              pick = i;
              best = age;
            end
          end
          if (pick < 0) begin
            idle = -1;
            never = -1;
            best = '0;
            for (int i = 0; i < ChunksPerClass; i++) begin
              age = class_clock[cls] - stamp_of[base + i];
              if (!active[base + i]) begin
                if (ever_used[base + i]) begin
                  if (idle < 0 || age > best) begin
                    idle = i;
                    best = age;
                  end
                end else if (never < 0) begin
                  never = i;
                end
              end
            end
            if (idle >= 0) pick = idle;
            else if (never >= 0) begin
              pick = never;
              r.fresh = 1'b1;
            end
            if (pick >= 0) begin
              x = base + pick;
              active[x] = 1;
              ever_used[x] = 1;
              linear_kind[x] = lin;
              slot_map[x] = '0;
              used_cnt[x] = 0;
              restamp(cls, x);
            end
          end
          if (pick < 0) begin
            r.st = ST_EXHAUSTED;
          end else begin
            x = base + pick;
            s = 0;
            while (s < n && slot_map[x][s]) s++;
            if (s >= n) begin
              r = '{st: ST_EXHAUSTED, default: '0};
            end else begin
              slot_map[x][s] = 1'b1;
              used_cnt[x]++;
              r.cls = 3'(cls);
              r.chunk = 4'(pick);
              r.off = 27'(s * bytes_per_slot(cls));
            end
          end
        end
      end else begin
        if (fcls >= ClassNum || fchunk >= ChunksPerClass) begin
          r.st = ST_BAD_FREE;
        end else begin
          s = foff / bytes_per_slot(fcls);
          x = fcls * ChunksPerClass + fchunk;
          if (s >= slot_count(fcls) || !active[x] || !slot_map[x][s] || used_cnt[x] == 0) begin
            r.st = ST_BAD_FREE;
          end else begin
            slot_map[x][s] = 1'b0;
            used_cnt[x]--;
            r.cls = fcls;
            r.chunk = fchunk;
            r.off = 27'(s * bytes_per_slot(fcls));
            if (used_cnt[x] == 0) begin
              active[x] = 0;
              restamp(fcls, x);
              r.rel = 1'b1;
            end
          end
        end
      end
      pending.push_back(r);
      status_seen[r.st]++;
      return r;
    endfunction

    function void check_result(slab_result_t got);
      slab_result_t w;
      if (pending.size() == 0) begin
        $error("unexpected response: status %0d", got.st);
        errors++;
        return;
      end
      w = pending.pop_front();
      n_checked++;
      if (got.st !== w.st) begin
        $error("status: expected %0d, actual %0d", w.st, got.st);
        errors++;
      end
      if (got.cls !== w.cls) begin
        $error("class_out: expected %0d, actual %0d", w.cls, got.cls);
        errors++;
      end
      if (got.chunk !== w.chunk) begin
        $error("chunk_out: expected %0d, actual %0d", w.chunk, got.chunk);
        errors++;
      end
      if (got.off !== w.off) begin
        $error("offset_out: expected %0d, actual %0d", w.off, got.off);
        errors++;
      end
      if (got.fresh !== w.fresh) begin
        $error("chunk_fresh: expected %0d, actual %0d", w.fresh, got.fresh);
        errors++;
      end
      if (got.rel !== w.rel) begin
        $error("chunk_released: expected %0d, actual %0d", w.rel, got.rel);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        cmd_i;
  logic [31:0] req_size_i;
  logic [31:0] req_align_i;
  logic        want_linear_i;
  logic [2:0]  free_class_i;
  logic [3:0]  free_chunk_i;
  logic [26:0] free_offset_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [2:0]  class_out_o;
  logic [3:0]  chunk_out_o;
  logic [26:0] offset_out_o;
  logic        chunk_fresh_o;
  logic        chunk_released_o;

  alloc_scoreboard sb;
  live_slot_t live[$];
  int unsigned idle_pct;
  int unsigned quiet_cycles;

  size_class_slab_allocator_core dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .req_size_i, .req_align_i,
    .want_linear_i, .free_class_i, .free_chunk_i, .free_offset_i, .done_o,
    .status_o, .class_out_o, .chunk_out_o, .offset_out_o, .chunk_fresh_o,
    .chunk_released_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result('{st: status_e'(status_o), cls: class_out_o, chunk: chunk_out_o,
                        off: offset_out_o, fresh: chunk_fresh_o, rel: chunk_released_o});
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // caller stands at a falling edge; returns at a falling edge, with start high or, after a random idle gap, low
  task automatic send_request(cmd_e cmd, logic [31:0] size, logic [31:0] align, logic lin,
                              logic [2:0] fcls, logic [3:0] fchunk, logic [26:0] foff);
    slab_result_t r;
    cmd_i = cmd;
    req_size_i = size;
    req_align_i = align;
    want_linear_i = lin;
    free_class_i = fcls;
    free_chunk_i = fchunk;
    free_offset_i = foff;
    start = 1'b1;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    r = sb.log_request(cmd, size, align, lin, fcls, fchunk, foff);
    if (cmd == CMD_ALLOC && r.st == ST_OK) live.push_back('{r.cls, r.chunk, r.off});
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  task automatic alloc_req(logic [31:0] size, logic [31:0] align, logic lin);
    send_request(CMD_ALLOC, size, align, lin, 3'($urandom), 4'($urandom), 27'($urandom));
  endtask

  task automatic free_req(logic [2:0] c, logic [3:0] k, logic [26:0] off);
    send_request(CMD_FREE, $urandom, $urandom, 1'($urandom), c, k, off);
  endtask

  task automatic free_live();
    int unsigned i;
    live_slot_t e;
    i = $urandom_range(live.size() - 1);
    e = live[i];
    live.delete(i);
    free_req(e.cls, e.chunk, 27'(e.off + $urandom_range(0, 255)));
  endtask

  task automatic random_request();
    int unsigned roll, c;
    logic [31:0] lo, hi, size, align;
    roll = $urandom_range(99);
    if (roll < 55 || live.size() == 0) begin
      c = $urandom_range(ClassNum - 1);
      lo = (c == 0) ? 32'd0 : sb.bytes_per_slot(c - 1);
      hi = sb.bytes_per_slot(c);
      size = lo + 1 + $urandom_range(0, hi - lo - 1);
      align = 32'd1 << $urandom_range(0, ($urandom_range(9) == 0) ? 31 : 12);
      alloc_req(size, align, $urandom_range(3) == 0);
    end else if (roll < 90) begin
      free_live();
    end else if (roll < 95) begin
      free_req(3'($urandom), 4'($urandom), 27'($urandom));
    end else begin
      alloc_req($urandom_range(1) ? $urandom : 0, $urandom_range(1) ? $urandom : 0,
                1'($urandom));
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 13;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = CMD_ALLOC;
    req_size_i = '0;
    req_align_i = '0;
    want_linear_i = 1'b0;
    free_class_i = '0;
    free_chunk_i = '0;
    free_offset_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    alloc_req(32'd1, 32'd1, 1'b0);
    alloc_req(32'd256, 32'd256, 1'b1);
    alloc_req(32'd257, 32'd1, 1'b0);
    alloc_req(32'd1, 32'd4096, 1'b0);
    alloc_req(32'd83886080, 32'd83886080, 1'b1);
    alloc_req(32'd83886080, 32'd1, 1'b1);
    alloc_req(32'd83886080, 32'd1, 1'b1);
    alloc_req(32'd83886081, 32'd1, 1'b0);
    alloc_req(32'hffffffff, 32'hffffffff, 1'b0);
    alloc_req(32'd0, 32'd8, 1'b0);
    alloc_req(32'd64, 32'd0, 1'b0);
    alloc_req(32'd64, 32'h80000000, 1'b0);
    alloc_req(32'd10485760, 32'd1, 1'b0);
    free_req(3'd6, 4'd0, 27'd0);
    free_req(3'd7, 4'd15, 27'h7ffffff);
    free_req(3'd0, 4'd15, 27'd0);
    free_req(3'd0, 4'd0, 27'h7ffffff);
    free_req(3'd0, 4'd0, 27'd300);
    free_req(3'd0, 4'd0, 27'd0);
    free_req(3'd0, 4'd0, 27'd0);
    free_req(3'd5, 4'd1, 27'd83886080);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 13 : (ph == 1) ? 73 : 0;
      for (int n = 0; n < 600; n++) random_request();
    end
    while (live.size() != 0) free_live();

    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    $display("checked %0d responses: ok %0d, no class %0d, exhausted %0d, bad free %0d",
             sb.n_checked, sb.status_seen[ST_OK], sb.status_seen[ST_NO_CLASS],
             sb.status_seen[ST_EXHAUSTED], sb.status_seen[ST_BAD_FREE]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/scsa_pkg.sv
design/scsa_ram.sv
design/scsa_class_sel.sv
design/size_class_slab_allocator_core.sv
design/scsa_checker.sv
verif/tb_size_class_slab_allocator_core.sv
